@@ sv/mbps_pkg.sv @@
// shared constants and types of the masked byte pattern scan
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int IDX_BITS    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int RESULT_BITS = 32;

    typedef logic [7:0] byte_t;
    typedef byte_t [PATTERN_MAX-1:0] byte_vec_t;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_CARE_MASK    = 2'd2,
        REG_PATTERN_LEN  = 2'd3
    } reg_idx_t;

endpackage

@@ sv/mbps_match.sv @@
// masked compare of the byte window against the pattern
module mbps_match (
    input  mbps_pkg::byte_vec_t                   window,
    input  mbps_pkg::byte_vec_t                   pattern,
    input  logic [mbps_pkg::PATTERN_MAX-1:0]      care,
    input  logic [mbps_pkg::LEN_BITS-1:0]         len,
    output logic                                  hit
);
    import mbps_pkg::*;

    // window[k] is the byte taken k words ago; pattern byte i lines up with window[len-1-i]
    always_comb begin
        logic [LEN_BITS-1:0] pos;
        hit = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos = len - LEN_BITS'(1) - LEN_BITS'(i);
            if ((LEN_BITS'(i) < len) && care[i]
                && (window[pos[IDX_BITS-1:0]] != pattern[i])) begin
                hit = 1'b0;
            end
        end
    end

endmodule

@@ sv/masked_byte_pattern_scan.sv @@
// top level: wildcard byte pattern search over a byte stream
//
// bytes of a region come in on the s_ channel, one word per byte, tlast on
// the final byte. a window of the 16 newest bytes is compared with the
// configured pattern (care_mask clear = wildcard) as each byte arrives.
// the first match gives one result word on the m_ channel: tuser = 1 and
// tdata = offset of the match start in the region. if the region ends with
// no match, the last byte gives tuser = 0, tdata = 0. bytes after a match
// up to tlast give no result. window, byte count and match flag clear after
// the last byte.
// latency: the result for a byte is valid the cycle after it is taken.
// throughput: one byte per cycle unless stalled; the compare and count
// logic sit between the window registers and the single output register.
// a stalled receiver holds the result word; a new byte is still taken
// while the output register is empty or being drained that cycle.
// reset clears the window, counter, output valid and the registers
// (pattern_length resets to 1). registers sit at apb byte addresses 0, 8,
// 16, 24; the user writes them only while the stream is idle (unenforced).
module masked_byte_pattern_scan (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [mbps_pkg::RESULT_BITS-1:0] m_tdata,  // [31:0] match_offset
    output logic        m_tuser    // found
);
    import mbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    logic [63:0]            pat_low_reg, pat_high_reg;
    logic [PATTERN_MAX-1:0] care_reg;
    logic [4:0]             len_reg;

    byte_vec_t              window_reg, window_next;
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   reported_reg;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [RESULT_BITS-1:0] out_offset_reg;

    byte_vec_t              pattern;
    logic [LEN_BITS-1:0]    eff_len;
    logic                   hit, match_now, take, wr_en;
    logic [OFFSET_BITS-1:0] offset_full;
    reg_idx_t               wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[4:3]);

    always_comb begin
        case (reg_idx_t'(paddr[4:3]))
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_CARE_MASK:    prdata = 64'(care_reg);
            REG_PATTERN_LEN:  prdata = 64'(len_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i < 8) pattern[i] = pat_low_reg[8*(i%8) +: 8];
            else       pattern[i] = pat_high_reg[8*(i%8) +: 8];
        end
    end

    // zero length acts as one, anything above the window size as the window size
    always_comb begin
        if (len_reg == 5'd0)
            eff_len = LEN_BITS'(1);
        else if (32'(len_reg) > PATTERN_MAX)
            eff_len = LEN_BITS'(PATTERN_MAX);
        else
            eff_len = LEN_BITS'(len_reg);
    end

    always_comb begin
        window_next[0] = s_tdata;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    assign count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + OFFSET_BITS'(1);
    assign offset_full = count_next - OFFSET_BITS'(eff_len);

    mbps_match u_match (
        .window  (window_next),
        .pattern (pattern),
        .care    (care_reg),
        .len     (eff_len),
        .hit     (hit)
    );

    assign match_now = !reported_reg && (count_next >= OFFSET_BITS'(eff_len)) && hit;
    assign s_tready  = !out_valid_reg || m_tready;
    assign take      = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= 5'd1;
        end else if (wr_en) begin
            case (wr_idx)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_CARE_MASK:    care_reg     <= pwdata[PATTERN_MAX-1:0];
                REG_PATTERN_LEN:  len_reg      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (take) begin
                if (s_tlast) begin
                    window_reg   <= '0;
                    count_reg    <= '0;
                    reported_reg <= 1'b0;
                end else begin
                    window_reg   <= window_next;
                    count_reg    <= count_next;
                    reported_reg <= reported_reg || match_now;
                end
                if (match_now || (s_tlast && !reported_reg))
                    out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_found_reg  <= match_now;
            out_offset_reg <= match_now ? RESULT_BITS'(offset_full) : '0;
        end
    end

endmodule

@@ verif/masked_byte_pattern_scan_tb.sv @@
// testbench for masked_byte_pattern_scan: directed and random regions checked against a predictor
`timescale 1ns / 100ps

module masked_byte_pattern_scan_tb;
    import mbps_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } scan_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [4:0]             paddr;
    logic [63:0]            pwdata;
    logic [63:0]            prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] data_byte
    logic                   s_tlast;   // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RESULT_BITS-1:0] m_tdata;   // [31:0] match_offset
    logic                   m_tuser;   // found

    // predictor copy of the registers and the scan state
    logic [63:0]   pat_lo  = '0;
    logic [63:0]   pat_hi  = '0;
    logic [15:0]   care    = '0;
    logic [4:0]    plen    = 5'd1;
    byte_t         win [PATTERN_MAX];
    logic [31:0]   seen    = '0;
    bit            matched = 1'b0;

    scan_result_t  scan_results_due[$];
    int            errors      = 0;
    int            items_sent  = 0;
    int            rx_wait     = 0;
    int            idle_cycles = 0;
    bit            idle_on     = 1'b1;

    masked_byte_pattern_scan u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 6) : 0;
    endfunction

    function automatic byte_t cfg_pattern_byte(input int i);
        logic [127:0] pat;
        pat = {pat_hi, pat_lo};
        return pat[8*i +: 8];
    endfunction

    function automatic int eff_pattern_len();
        if (plen == 0)
            return 1;
        if (plen > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(plen);
    endfunction

    // mostly random, sometimes a pattern byte so partial matches occur
    function automatic byte_t fill_byte();
        if ($urandom_range(0, 3) == 0)
            return cfg_pattern_byte($urandom_range(0, eff_pattern_len() - 1));
        return byte_t'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic predict_scan(input byte_t b, input logic last);
        scan_result_t res;
        int len;
        bit hit;
        len = eff_pattern_len();
        for (int k = PATTERN_MAX - 1; k > 0; k--)
            win[k] = win[k-1];
        win[0] = b;
        if (seen != 32'hFFFF_FFFF)
            seen++;
        if (!matched && seen >= 32'(len)) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (care[i] && win[len-1-i] != cfg_pattern_byte(i))
                    hit = 1'b0;
            if (hit) begin
                matched    = 1'b1;
                res.found  = 1'b1;
                res.offset = seen - 32'(len);
                scan_results_due.push_back(res);
            end
        end
        if (last) begin
            if (!matched) begin
                res.found  = 1'b0;
                res.offset = '0;
                scan_results_due.push_back(res);
            end
            foreach (win[k])
                win[k] = '0;
            seen    = '0;
            matched = 1'b0;
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  pat_lo = value;
            REG_PATTERN_HIGH: pat_hi = value;
            REG_CARE_MASK:    care   = value[15:0];
            REG_PATTERN_LEN:  plen   = value[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_byte(input byte_t b, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        predict_scan(b, last);
    endtask

    // stop the stream and wait for every pending result, then some spare cycles
    task automatic hold_until_drained(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (scan_results_due.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic send_region(input byte_t bytes[$], input int pause_at);
        for (int k = 0; k < bytes.size(); k++) begin
            if (k == pause_at)
                hold_until_drained(0);
            send_byte(bytes[k], k == bytes.size() - 1);
        end
    endtask

    // reset values: length 1, no care bits, so the first byte matches
    task automatic test_reset_values();
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h00, 1'b1);
        hold_until_drained(4);
    endtask

    task automatic test_directed_cases();
        // length 0 acts as 1; the matching last byte after a match gives nothing
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
        write_reg(REG_PATTERN_HIGH, 64'h0);
        write_reg(REG_CARE_MASK, 64'h1);
        write_reg(REG_PATTERN_LEN, 64'h0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        hold_until_drained(4);

        // length 31 acts as 16, every byte cared
        write_reg(REG_PATTERN_LOW, 64'hFE7F_8001_AA55_FF00);
        write_reg(REG_PATTERN_HIGH, 64'hF0DE_BC9A_7856_3412);
        write_reg(REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_LEN, 64'd31);
        // region shorter than the pattern
        for (int i = 0; i < 3; i++)
            send_byte(cfg_pattern_byte(i), i == 2);
        // full pattern that completes on the last byte
        for (int i = 0; i < PATTERN_MAX; i++)
            send_byte(cfg_pattern_byte(i), i == PATTERN_MAX - 1);
        hold_until_drained(4);
    endtask

    task automatic test_random_regions();
        byte_t bytes[$];
        int    cared[$];
        int    len, pos, pre, post, kind, nregions, pause_at, r;
        logic [63:0] len_val, care_val;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       len_val = 64'd0;
                1:       len_val = 64'($urandom_range(17, 31));
                2:       len_val = 64'(PATTERN_MAX);
                3:       len_val = 64'd1;
                default: len_val = 64'($urandom_range(1, PATTERN_MAX));
            endcase
            r = $urandom_range(0, 5);
            case (r)
                0:       care_val = 64'h0;
                1:       care_val = 64'hFFFF_FFFF_FFFF_FFFF;
                default: care_val = {$urandom, $urandom};
            endcase
            write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
            write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
            write_reg(REG_CARE_MASK, care_val);
            write_reg(REG_PATTERN_LEN, len_val);
            idle_on  = ($urandom_range(0, 3) != 0);
            len      = eff_pattern_len();
            nregions = $urandom_range(3, 8);
            for (int n = 0; n < nregions; n++) begin
                bytes.delete();
                kind = $urandom_range(0, 9);
                if (kind == 8) begin
                    // short region, may still hit through wildcards
                    repeat ($urandom_range(1, len)) bytes.push_back(fill_byte());
                end else begin
                    pre  = $urandom_range(0, 12);
                    post = (kind == 9) ? 0 : $urandom_range(0, 12);
                    repeat (pre) bytes.push_back(fill_byte());
                    pos = bytes.size();
                    for (int i = 0; i < len; i++)
                        bytes.push_back(care[i] ? cfg_pattern_byte(i) : fill_byte());
                    repeat (post) bytes.push_back(fill_byte());
                    if (kind == 6 || kind == 7) begin
                        // near miss: spoil one cared byte
                        cared.delete();
                        for (int i = 0; i < len; i++)
                            if (care[i])
                                cared.push_back(i);
                        if (cared.size() != 0) begin
                            r = cared[$urandom_range(0, cared.size() - 1)];
                            bytes[pos + r] = bytes[pos + r] ^ byte_t'($urandom_range(1, 255));
                        end
                    end
                end
                pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, bytes.size() - 1) : -1;
                send_region(bytes, pause_at);
            end
            hold_until_drained(4);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin : rx_side
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (scan_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          m_tuser, m_tdata));
            end else begin
                want = scan_results_due.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b", m_tuser, want.found));
                if (m_tdata !== want.offset)
                    report_mismatch($sformatf("match_offset %0d, want %0d",
                                              m_tdata, want.offset));
            end
            rx_wait = draw_gap();
        end
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        foreach (win[k])
            win[k] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directed_cases();
        test_random_regions();

        hold_until_drained(10);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/mbps_pkg.sv
sv/mbps_match.sv
sv/masked_byte_pattern_scan.sv
verif/masked_byte_pattern_scan_tb.sv
